>>> rtl/pcc_pkg.sv
// pcc_pkg: word types, fixed-point widths and CORDIC constants for the
// polar/Cartesian converter. No dependencies.
`default_nettype none

package pcc_pkg;

  // Input word: mode plus two Q7.8 / Q2.13 operands
  typedef struct packed {
    logic               mode;
    logic signed [15:0] first_operand;
    logic signed [15:0] second_operand;
  } pcc_in_t;

  // Result word
  typedef struct packed {
    logic signed [16:0] first_result;
    logic signed [15:0] second_result;
  } pcc_out_t;

  // Datapath widths: x/y carry 24 fraction bits, gain growth needs headroom
  localparam int XY_W      = 35;
  localparam int Z_W       = 30;
  localparam int TABLE_LEN = 24;

  localparam logic       MODE_ROTATE = 1'b0;
  localparam logic       MODE_VECTOR = 1'b1;

  localparam logic signed [Z_W-1:0] PI_Q24      = 30'sd52707179;
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 30'sd26353589;
  localparam logic        [23:0]    INV_GAIN_Q24 = 24'd10188014;

  // atan(2^-i) in Q24
  localparam logic [23:0] ATAN_Q24 [0:TABLE_LEN-1] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

  // Vector state carried down the CORDIC pipeline
  typedef struct packed {
    logic                  mode;
    logic                  zero;   // vectoring input at the origin
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } pcc_vec_t;

endpackage

`default_nettype wire

>>> rtl/pcc_stage.sv
// pcc_stage: one registered CORDIC micro-rotation with a fixed shift.
// Depends on pcc_pkg.
`default_nettype none

module pcc_stage
  import pcc_pkg::*;
#(
  parameter int STAGE_IDX = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     valid_i,
  input  wire pcc_vec_t vec_i,
  output logic          valid_o,
  output pcc_vec_t      vec_o
);

  localparam logic signed [Z_W-1:0] ANGLE =
    $signed({{(Z_W-24){1'b0}}, ATAN_Q24[STAGE_IDX]});

  logic                   valid_r;
  pcc_vec_t               vec_r;
  pcc_vec_t               vec_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic                   sel;

  // Shifts round toward minus infinity (arithmetic shift)
  assign xs = $signed(vec_i.x) >>> STAGE_IDX;
  assign ys = $signed(vec_i.y) >>> STAGE_IDX;

  // Rotating: drive z to 0. Vectoring: drive y to 0. Both share one datapath.
  assign sel = (vec_i.mode == MODE_VECTOR) ? vec_i.y[XY_W-1] : ~vec_i.z[Z_W-1];

  always_comb begin
    vec_nxt = vec_i;
    if (sel) begin
      vec_nxt.x = $signed(vec_i.x) - ys;
      vec_nxt.y = $signed(vec_i.y) + xs;
      vec_nxt.z = $signed(vec_i.z) - ANGLE;
    end else begin
      vec_nxt.x = $signed(vec_i.x) + ys;
      vec_nxt.y = $signed(vec_i.y) - xs;
      vec_nxt.z = $signed(vec_i.z) + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign valid_o = valid_r;
  assign vec_o   = vec_r;

endmodule

`default_nettype wire

>>> rtl/polar_cartesian_converter.sv
// polar_cartesian_converter: pipelined CORDIC, polar <-> Cartesian.
// Registers from accept to out_valid, in order:
//   pre-rotation register (loaded at accept), one per micro-rotation, gain multiply, round/clamp.
// Throughput: one word per cycle; the whole pipeline holds while out_valid && !out_ready.
// Reset: synchronous active-low rst_n clears all valid bits; payload registers are not reset.
// Depends on pcc_pkg and pcc_stage.
`default_nettype none

module polar_cartesian_converter
  import pcc_pkg::*;
#(
  parameter int ITERATIONS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire pcc_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output pcc_out_t     out_data
);

  localparam int PROD_W = XY_W + 25;
  localparam int Q_W    = PROD_W - 40;
  localparam int ZQ_W   = Z_W - 11;

  localparam logic signed [PROD_W-1:0] ROUND_Q8 = PROD_W'(64'sd1 <<< 39);
  localparam logic signed [Q_W-1:0]    SAT_HI   = Q_W'(32767);
  localparam logic signed [Q_W-1:0]    SAT_LO   = -Q_W'(32768);
  localparam logic signed [Q_W-1:0]    RAD_HI   = Q_W'(46341);
  localparam logic signed [ZQ_W-1:0]   ZSAT_HI  = ZQ_W'(32767);
  localparam logic signed [ZQ_W-1:0]   ZSAT_LO  = -ZQ_W'(32768);
  localparam logic signed [Z_W-1:0]    ZROUND   = Z_W'(1024);

  logic adv;

  // Global advance: everything moves unless a result is stuck at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------
  // Pre-rotation into the CORDIC convergence range
  // ---------------------------------------------------------------
  pcc_vec_t               pre_nxt;
  pcc_vec_t               pre_vec_r;
  logic                   pre_vld_r;
  logic signed [XY_W-1:0] a_q24;
  logic signed [XY_W-1:0] b_q24;
  logic signed [Z_W-1:0]  ang_q24;

  assign a_q24   = $signed({{(XY_W-32){in_data.first_operand[15]}}, in_data.first_operand,
                            16'b0});
  assign b_q24   = $signed({{(XY_W-32){in_data.second_operand[15]}}, in_data.second_operand,
                            16'b0});
  assign ang_q24 = $signed({{(Z_W-27){in_data.second_operand[15]}}, in_data.second_operand,
                            11'b0});

  always_comb begin
    pre_nxt.mode = in_data.mode;
    pre_nxt.zero = (in_data.mode == MODE_VECTOR) &&
                   (in_data.first_operand == '0) && (in_data.second_operand == '0);
    if (in_data.mode == MODE_ROTATE) begin
      // Rotate (r, 0) by the angle; fold angles beyond +-pi/2 by pi
      pre_nxt.y = '0;
      if (ang_q24 > HALF_PI_Q24) begin
        pre_nxt.x = -a_q24;
        pre_nxt.z = ang_q24 - PI_Q24;
      end else if (ang_q24 < -HALF_PI_Q24) begin
        pre_nxt.x = -a_q24;
        pre_nxt.z = ang_q24 + PI_Q24;
      end else begin
        pre_nxt.x = a_q24;
        pre_nxt.z = ang_q24;
      end
    end else begin
      // Vectoring: mirror left half-plane, start angle at +-pi
      if (a_q24[XY_W-1]) begin
        pre_nxt.x = -a_q24;
        pre_nxt.y = -b_q24;
        pre_nxt.z = b_q24[XY_W-1] ? -PI_Q24 : PI_Q24;
      end else begin
        pre_nxt.x = a_q24;
        pre_nxt.y = b_q24;
        pre_nxt.z = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (adv) begin
      pre_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_vec_r <= pre_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Micro-rotation pipeline
  // ---------------------------------------------------------------
  pcc_vec_t stage_vec [0:ITERATIONS];
  logic     stage_vld [0:ITERATIONS];

  assign stage_vec[0] = pre_vec_r;
  assign stage_vld[0] = pre_vld_r;

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
    pcc_stage #(
      .STAGE_IDX (k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (stage_vld[k]),
      .vec_i   (stage_vec[k]),
      .valid_o (stage_vld[k+1]),
      .vec_o   (stage_vec[k+1])
    );
  end

  // ---------------------------------------------------------------
  // Gain removal multiply
  // ---------------------------------------------------------------
  pcc_vec_t                 fin_vec;
  logic signed [PROD_W-1:0] mul_x_r;
  logic signed [PROD_W-1:0] mul_y_r;
  logic signed [Z_W-1:0]    mul_z_r;
  logic                     mul_mode_r;
  logic                     mul_zero_r;
  logic                     mul_vld_r;
  logic signed [24:0]       inv_gain;

  assign fin_vec  = stage_vec[ITERATIONS];
  assign inv_gain = $signed({1'b0, INV_GAIN_Q24});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (adv) begin
      mul_vld_r <= stage_vld[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_x_r    <= $signed(fin_vec.x) * inv_gain;
      mul_y_r    <= $signed(fin_vec.y) * inv_gain;
      mul_z_r    <= fin_vec.z;
      mul_mode_r <= fin_vec.mode;
      mul_zero_r <= fin_vec.zero;
    end
  end

  // ---------------------------------------------------------------
  // Round half up, saturate, output register
  // ---------------------------------------------------------------
  logic signed [PROD_W-1:0] rx_sum;
  logic signed [PROD_W-1:0] ry_sum;
  logic signed [Q_W-1:0]    qx;
  logic signed [Q_W-1:0]    qy;
  logic signed [Z_W-1:0]    z_sum;
  logic signed [ZQ_W-1:0]   qz;
  pcc_out_t                 out_nxt;
  pcc_out_t                 out_data_r;
  logic                     out_valid_r;

  assign rx_sum = mul_x_r + ROUND_Q8;
  assign ry_sum = mul_y_r + ROUND_Q8;
  assign qx     = rx_sum[PROD_W-1:40];
  assign qy     = ry_sum[PROD_W-1:40];
  assign z_sum  = mul_z_r + ZROUND;
  assign qz     = z_sum[Z_W-1:11];

  always_comb begin
    out_nxt = '0;
    if (mul_mode_r == MODE_ROTATE) begin
      if (qx > SAT_HI) begin
        out_nxt.first_result = 17'sd32767;
      end else if (qx < SAT_LO) begin
        out_nxt.first_result = -17'sd32768;
      end else begin
        out_nxt.first_result = qx[16:0];
      end
      if (qy > SAT_HI) begin
        out_nxt.second_result = 16'sd32767;
      end else if (qy < SAT_LO) begin
        out_nxt.second_result = -16'sd32768;
      end else begin
        out_nxt.second_result = qy[15:0];
      end
    end else if (!mul_zero_r) begin
      if (qx > RAD_HI) begin
        out_nxt.first_result = 17'sd46341;
      end else if (qx[Q_W-1]) begin
        out_nxt.first_result = '0;
      end else begin
        out_nxt.first_result = qx[16:0];
      end
      if (qz > ZSAT_HI) begin
        out_nxt.second_result = 16'sd32767;
      end else if (qz < ZSAT_LO) begin
        out_nxt.second_result = -16'sd32768;
      end else begin
        out_nxt.second_result = qz[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // An accepted word lands in the pre-rotation register
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> pre_vld_r)
    else $error("accepted word did not enter the pipeline");

  // Vectoring keeps x on the nonnegative axis
  a_vector_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r && (mul_mode_r == MODE_VECTOR) |-> !mul_x_r[PROD_W-1])
    else $error("vectoring x went negative");

  // Origin in vectoring mode gives zero radius and angle
  a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r && (mul_mode_r == MODE_VECTOR) && mul_zero_r && adv |=> out_data_r == '0)
    else $error("origin did not give zero result");

  // A stall freezes the multiply stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r && !adv |=> $stable(mul_x_r) && $stable(mul_y_r) && mul_vld_r)
    else $error("multiply stage changed during stall");
`endif

endmodule

`default_nettype wire

>>> tb/tb_polar_cartesian_converter.sv
`timescale 1ns / 1ps
// tb_polar_cartesian_converter: self-checking testbench for the CORDIC polar/Cartesian
// converter. It predicts every word with its own fixed-point CORDIC. Needs pcc_pkg and the RTL.

module tb_polar_cartesian_converter
  import pcc_pkg::*;
();

  localparam int     CORDIC_STEPS = 16;
  localparam int     PIPE_LATENCY = CORDIC_STEPS + 3;
  localparam longint ROT_PI       = 64'sd52707179;
  localparam longint ROT_HALF_PI  = 64'sd26353589;
  localparam longint GAIN_INV     = 64'sd10188014;
  localparam longint Q40_HALF     = 64'sd549755813888;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  pcc_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  pcc_out_t out_data;

  pcc_out_t expected_coords[$];
  pcc_out_t want;
  int       error_count   = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles   = 0;

  polar_cartesian_converter #(.ITERATIONS(CORDIC_STEPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // atan(2^-i) in Q24
  function automatic longint step_angle(input int i);
    case (i)
      0: return 13176795;
      1: return 7778716;
      2: return 4110060;
      3: return 2086331;
      4: return 1047214;
      5: return 524117;
      6: return 262123;
      7: return 131069;
      default: return longint'(1) << (24 - i);  // atan(2^-i) == 2^-i from here on
    endcase
  endfunction

  // drop the CORDIC gain and round Q24 half up to Q8
  function automatic longint unscale_to_q8(input longint v);
    return (v * GAIN_INV + Q40_HALF) >>> 40;
  endfunction

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic pcc_out_t convert_coords(input pcc_in_t w);
    longint   a, b, px, py, pz, nx, r0, r1;
    pcc_out_t res;
    a = longint'(w.first_operand);
    b = longint'(w.second_operand);
    if (w.mode == MODE_ROTATE) begin
      px = a * 65536;
      py = 0;
      pz = b * 2048;
      // angles past +-pi/2 are moved by pi and the vector flipped
      if (pz > ROT_HALF_PI) begin
        pz = pz - ROT_PI;
        px = -px;
      end else if (pz < -ROT_HALF_PI) begin
        pz = pz + ROT_PI;
        px = -px;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        if (pz >= 0) begin
          nx = px - (py >>> i);
          py = py + (px >>> i);
          pz = pz - step_angle(i);
        end else begin
          nx = px + (py >>> i);
          py = py - (px >>> i);
          pz = pz + step_angle(i);
        end
        px = nx;
      end
      r0 = saturate(unscale_to_q8(px), -32768, 32767);
      r1 = saturate(unscale_to_q8(py), -32768, 32767);
    end else if (a == 0 && b == 0) begin
      // origin: radius and angle both zero
      r0 = 0;
      r1 = 0;
    end else begin
      px = a * 65536;
      py = b * 65536;
      pz = 0;
      // left half plane: flip the vector, start from +pi or -pi
      if (px < 0) begin
        pz = (py >= 0) ? ROT_PI : -ROT_PI;
        px = -px;
        py = -py;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        if (py >= 0) begin
          nx = px + (py >>> i);
          py = py - (px >>> i);
          pz = pz + step_angle(i);
        end else begin
          nx = px - (py >>> i);
          py = py + (px >>> i);
          pz = pz - step_angle(i);
        end
        px = nx;
      end
      r0 = saturate(unscale_to_q8(px), 0, 46341);
      r1 = saturate((pz + 1024) >>> 11, -32768, 32767);
    end
    res.first_result  = r0[16:0];
    res.second_result = r1[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic pcc_in_t make_word(input logic m, input logic signed [15:0] p,
                                        input logic signed [15:0] q);
    pcc_in_t w;
    w.mode           = m;
    w.first_operand  = p;
    w.second_operand = q;
    return w;
  endfunction

  function automatic logic signed [15:0] random_operand(input bit is_angle);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6:    return 16'($urandom_range(0, 1024) - 512);
      7: begin
        case ($urandom_range(0, 4))
          0:       return 16'sd0;
          1:       return 16'sd1;
          2:       return -16'sd1;
          3:       return 16'sd32767;
          default: return -16'sd32768;
        endcase
      end
      // angles mostly within +-pi, coordinates moderate
      default: return is_angle ? 16'($urandom_range(0, 51472) - 25736)
                               : 16'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  function automatic pcc_in_t random_word();
    pcc_in_t w;
    w.mode           = $urandom_range(0, 1) ? MODE_VECTOR : MODE_ROTATE;
    w.first_operand  = random_operand(1'b0);
    w.second_operand = random_operand(w.mode == MODE_ROTATE);
    return w;
  endfunction

  // offer one word, wait for the handshake, record its prediction
  task automatic send_word(input pcc_in_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_coords.push_back(convert_coords(w));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_coords.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_rotation_corners();
    send_word(make_word(MODE_ROTATE, 32767, 0));
    send_word(make_word(MODE_ROTATE, 32767, 12868));     // +pi/2
    send_word(make_word(MODE_ROTATE, 32767, -12868));
    send_word(make_word(MODE_ROTATE, 32767, 12869));     // just past pi/2
    send_word(make_word(MODE_ROTATE, 32767, -12869));
    send_word(make_word(MODE_ROTATE, 32767, 25736));     // +pi
    send_word(make_word(MODE_ROTATE, 32767, -25736));
    send_word(make_word(MODE_ROTATE, 32767, 32767));     // beyond pi
    send_word(make_word(MODE_ROTATE, 32767, -32768));
    send_word(make_word(MODE_ROTATE, -32768, 6434));     // negative radius
    send_word(make_word(MODE_ROTATE, -32768, -32768));
    send_word(make_word(MODE_ROTATE, 0, -32768));
    send_word(make_word(MODE_ROTATE, 256, 6434));
  endtask

  task automatic test_vectoring_corners();
    send_word(make_word(MODE_VECTOR, 0, 0));             // origin
    send_word(make_word(MODE_VECTOR, 32767, 32767));
    send_word(make_word(MODE_VECTOR, -32768, -32768));   // radius clamp
    send_word(make_word(MODE_VECTOR, -32768, 0));        // negative x axis
    send_word(make_word(MODE_VECTOR, -256, -1));
    send_word(make_word(MODE_VECTOR, 0, 32767));
    send_word(make_word(MODE_VECTOR, 0, -32768));
    send_word(make_word(MODE_VECTOR, 32767, -32768));
    send_word(make_word(MODE_VECTOR, -1, 1));
    send_word(make_word(MODE_VECTOR, 256, 0));
    send_word(make_word(MODE_VECTOR, 1, 0));
    send_word(make_word(MODE_VECTOR, 0, 1));
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) send_word(random_word());
  endtask

  // long output stall with a busy sender: the pipeline fills and holds its input
  task automatic test_output_stall();
    int saved_pct;
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    hold_cycles   = 80;
    test_random_traffic(50);
    send_idle_pct = saved_pct;
  endtask

  // sender stops until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    test_random_traffic(30);
    wait_for_drain();
    test_random_traffic(30);
  endtask

  // ---------------------------------------------------------------- receiver and checker

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_coords.size() == 0) begin
        note_error($sformatf("unexpected word %0d / %0d",
                             out_data.first_result, out_data.second_result));
      end else begin
        want = expected_coords.pop_front();
        if (out_data.first_result !== want.first_result)
          note_error($sformatf("first_result expected %0d got %0d",
                               want.first_result, out_data.first_result));
        if (out_data.second_result !== want.second_result)
          note_error($sformatf("second_result expected %0d got %0d",
                               want.second_result, out_data.second_result));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 69;
    test_rotation_corners();
    test_vectoring_corners();
    test_random_traffic(220);
    test_output_stall();

    send_idle_pct = 69;
    recv_idle_pct = 24;
    test_random_traffic(220);
    test_drain_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(220);

    wait_for_drain();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (expected_coords.size() != 0)
      note_error($sformatf("%0d words never came out", expected_coords.size()));

    if (error_count == 0) begin
      $display("tb_polar_cartesian_converter: clean");
    end else begin
      $display("tb_polar_cartesian_converter: errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("tb_polar_cartesian_converter: errors");
    $finish;
  end

endmodule
